[hdl/quaternion_nlerp_defines.svh]
// Assertion macros used by the checker file of the quaternion blend block.
// Each macro expects signal clk, and all but QN_ASSERT_ALWAYS also rst_n, in the scope where it is used.
`ifndef QUATERNION_NLERP_DEFINES_SVH
`define QUATERNION_NLERP_DEFINES_SVH

// implication in the same cycle, skipped while in reset
`define QN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, skipped while in reset
`define QN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// implication in the next cycle, also checked across reset
`define QN_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/qnlerp_pkg.sv]
// Shared constants for the quaternion normalized blend block.
// No dependencies; used by the top level, its checker and the test bench.
package qnlerp_pkg;

  localparam int             Q_LANES       = 4;
  localparam int             BLEND_W       = 17;
  localparam int             BLEND_FRAC    = 16;
  localparam logic [16:0]    BLEND_ONE     = 17'h10000;
  localparam int             BLEND_HALF    = 32768;
  localparam int             MIN_MAG_W     = 15;
  localparam logic [14:0]    MIN_MAG_RESET = 15'd2;

endpackage

[hdl/quaternion_nlerp.sv]
// Normalized linear blend of two fixed-point quaternions, fully pipelined.
// Depends on qnlerp_pkg.
//
// Usage:
//   in_*  : one transaction carries quaternions a, b and blend factor t.
//   out_* : one transaction per input, the blended and normalized quaternion;
//           out_tuser is set when the length was at or below min_magnitude and
//           the identity (0,0,0,1) was returned instead.
//   cfg_* : writes min_magnitude (15 bits, unsigned Q1.14); always ready. Write only
//           while no transaction is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
//   The depth is set by the bit-serial square root (COMPONENT_BITS+2 stages)
//   and the bit-serial divider (COMPONENT_BITS-1 stages), one bit per stage.
// Reset: synchronous, active low; empties the pipeline and sets
//   min_magnitude to 2.
// Stall: when out_tready is low and the output holds a result, the whole
//   pipeline freezes and in_tready drops; nothing is lost or repeated.
module quaternion_nlerp #(
  parameter int COMPONENT_BITS = 16,
  localparam int IN_TDW  = ((8 * COMPONENT_BITS + qnlerp_pkg::BLEND_W + 7) / 8) * 8,
  localparam int OUT_TDW = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend (low bits first)
  input  logic [IN_TDW-1:0]                   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_x, out_y, out_z, out_w (low bits first)
  output logic [OUT_TDW-1:0]                  out_tdata,
  // fell_to_identity
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qnlerp_pkg::MIN_MAG_W-1:0]    cfg_data
);
  import qnlerp_pkg::*;

  localparam int W   = COMPONENT_BITS;
  localparam int F   = W - 2;
  localparam int PDW = 2 * W;
  localparam int DTW = 2 * W + 2;
  localparam int DW  = W + 2;
  localparam int PW  = DW + BLEND_W + 1;
  localparam int FW  = PW + 1;
  localparam int MW  = W + 1;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW / 2;
  localparam int QB  = F + 1;
  localparam int NW  = MW + F + 1;
  localparam int CW  = (SW > 2 * MIN_MAG_W) ? SW : 2 * MIN_MAG_W;
  localparam int NV  = 9 + RW + QB;
  localparam logic [W-1:0] ONE_Q = W'(1) << F;

  logic en;
  logic [NV-1:0] vld_r;

  // configuration register
  logic [MIN_MAG_W-1:0] min_mag_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_mag_r <= MIN_MAG_RESET;
    end else if (cfg_valid) begin
      min_mag_r <= cfg_data;
    end
  end

  // global advance: the pipeline moves unless a result waits at the output
  assign en        = !vld_r[NV-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_tvalid};
    end
  end

  // stage 0: capture inputs, clamp blend to one
  logic signed [W-1:0] a0_r [Q_LANES];
  logic signed [W-1:0] b0_r [Q_LANES];
  logic [BLEND_W-1:0]  t0_r;
  logic [BLEND_W-1:0]  t_in;
  assign t_in = in_tdata[8*W +: BLEND_W];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        a0_r[i] <= in_tdata[i*W +: W];
        b0_r[i] <= in_tdata[(Q_LANES+i)*W +: W];
      end
      t0_r <= (t_in > BLEND_ONE) ? BLEND_ONE : t_in;
    end
  end

  // stage 1: dot product terms
  logic signed [PDW-1:0] p1_r [Q_LANES];
  logic signed [W-1:0]   a1_r [Q_LANES];
  logic signed [W-1:0]   b1_r [Q_LANES];
  logic [BLEND_W-1:0]    t1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        p1_r[i] <= a0_r[i] * b0_r[i];
        a1_r[i] <= a0_r[i];
        b1_r[i] <= b0_r[i];
      end
      t1_r <= t0_r;
    end
  end

  // stage 2: dot sign picks the shorter arc, form b' - a
  logic signed [DTW-1:0] dot;
  logic                  dneg;
  assign dot  = DTW'(p1_r[0]) + DTW'(p1_r[1]) + DTW'(p1_r[2]) + DTW'(p1_r[3]);
  assign dneg = dot[DTW-1];

  logic signed [DW-1:0] d2_r [Q_LANES];
  logic signed [W-1:0]  a2_r [Q_LANES];
  logic [BLEND_W-1:0]   t2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        d2_r[i] <= dneg ? (-DW'(b1_r[i]) - DW'(a1_r[i]))
                        : (DW'(b1_r[i]) - DW'(a1_r[i]));
        a2_r[i] <= a1_r[i];
      end
      t2_r <= t1_r;
    end
  end

  // stage 3: scale the difference by t
  logic signed [PW-1:0] pr3_r [Q_LANES];
  logic signed [W-1:0]  a3_r  [Q_LANES];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        pr3_r[i] <= d2_r[i] * $signed({1'b0, t2_r});
        a3_r[i]  <= a2_r[i];
      end
    end
  end

  // stage 4: add a, round to component format, split sign and magnitude
  logic signed [FW-1:0] full [Q_LANES];
  logic [MW:0]          rnd  [Q_LANES];
  logic [MW-1:0]        m4_r [Q_LANES];
  logic [Q_LANES-1:0]   s4_r;
  always_comb begin
    for (int i = 0; i < Q_LANES; i++) begin
      full[i] = (FW'(a3_r[i]) <<< BLEND_FRAC) + FW'(pr3_r[i]) + FW'(BLEND_HALF);
      rnd[i]  = full[i][BLEND_FRAC +: MW+1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        s4_r[i] <= rnd[i][MW];
        m4_r[i] <= rnd[i][MW] ? MW'(-rnd[i]) : rnd[i][MW-1:0];
      end
    end
  end

  // stage 5: squares
  logic [2*MW-1:0]    q5_r [Q_LANES];
  logic [MW-1:0]      m5_r [Q_LANES];
  logic [Q_LANES-1:0] s5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        q5_r[i] <= m4_r[i] * m4_r[i];
        m5_r[i] <= m4_r[i];
      end
      s5_r <= s4_r;
    end
  end

  // stage 6: sum of squares, saturate at 64 bits, threshold test
  logic [SW-1:0] ssum;
  logic [SW-1:0] ssat;
  logic [CW-1:0] thr_sq;
  assign ssum   = SW'(q5_r[0]) + SW'(q5_r[1]) + SW'(q5_r[2]) + SW'(q5_r[3]);
  assign thr_sq = CW'(min_mag_r) * CW'(min_mag_r);
  generate
    if (SW > 64) begin : g_sat
      assign ssat = (|ssum[SW-1:64]) ? {{(SW-64){1'b0}}, {64{1'b1}}} : ssum;
    end else begin : g_nosat
      assign ssat = ssum;
    end
  endgenerate

  // square root pipeline, index 0 is stage 6
  logic [RW+1:0]      sr_r [RW+1];
  logic [RW-1:0]      sq_r [RW+1];
  logic [SW-1:0]      ss_r [RW+1];
  logic [MW-1:0]      sm_r [RW+1][Q_LANES];
  logic [Q_LANES-1:0] sg_r [RW+1];
  logic               si_r [RW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= '0;
      sq_r[0] <= '0;
      ss_r[0] <= ssat;
      sm_r[0] <= m5_r;
      sg_r[0] <= s5_r;
      si_r[0] <= !(CW'(ssat) > thr_sq);
    end
  end

  generate
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
      logic [RW+3:0] cur;
      logic [RW+3:0] trial;
      logic          ge;
      assign cur   = {sr_r[j], ss_r[j][SW-1 -: 2]};
      assign trial = {2'b00, sq_r[j], 2'b01};
      assign ge    = cur >= trial;
      // one root bit per stage
      always_ff @(posedge clk) begin
        if (en) begin
          sr_r[j+1] <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
          sq_r[j+1] <= {sq_r[j][RW-2:0], ge};
          ss_r[j+1] <= ss_r[j] << 2;
          sm_r[j+1] <= sm_r[j];
          sg_r[j+1] <= sg_r[j];
          si_r[j+1] <= si_r[j];
        end
      end
    end
  endgenerate

  // divider pipeline, index 0 forms the rounded numerator
  logic [RW-1:0]      dr_r   [QB+1][Q_LANES];
  logic [QB-1:0]      dn_r   [QB+1][Q_LANES];
  logic [QB-1:0]      dq_r   [QB+1][Q_LANES];
  logic [RW-1:0]      dmag_r [QB+1];
  logic [Q_LANES-1:0] dsg_r  [QB+1];
  logic               di_r   [QB+1];
  logic [NW-1:0]      numr   [Q_LANES];

  always_comb begin
    for (int i = 0; i < Q_LANES; i++) begin
      numr[i] = (NW'(sm_r[RW][i]) << F) + NW'(sq_r[RW] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        dr_r[0][i] <= RW'(numr[i][NW-1:QB]);
        dn_r[0][i] <= numr[i][QB-1:0];
        dq_r[0][i] <= '0;
      end
      dmag_r[0] <= sq_r[RW];
      dsg_r[0]  <= sg_r[RW];
      di_r[0]   <= si_r[RW];
    end
  end

  generate
    for (genvar k = 0; k < QB; k++) begin : g_div
      for (genvar i = 0; i < Q_LANES; i++) begin : g_lane
        logic [RW:0] cur;
        logic        ge;
        assign cur = {dr_r[k][i], dn_r[k][i][QB-1]};
        assign ge  = cur >= {1'b0, dmag_r[k]};
        // one quotient bit per stage and lane
        always_ff @(posedge clk) begin
          if (en) begin
            dr_r[k+1][i] <= ge ? RW'(cur - {1'b0, dmag_r[k]}) : RW'(cur);
            dn_r[k+1][i] <= dn_r[k][i] << 1;
            dq_r[k+1][i] <= {dq_r[k][i][QB-2:0], ge};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dmag_r[k+1] <= dmag_r[k];
          dsg_r[k+1]  <= dsg_r[k];
          di_r[k+1]   <= di_r[k];
        end
      end
    end
  endgenerate

  // output register: restore sign or substitute identity
  logic [W-1:0] ov_r [Q_LANES];
  logic         oid_r;
  logic [W-1:0] qe   [Q_LANES];
  always_comb begin
    for (int i = 0; i < Q_LANES; i++) begin
      qe[i] = W'(dq_r[QB][i]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_LANES; i++) begin
        if (di_r[QB]) begin
          ov_r[i] <= (i == Q_LANES - 1) ? ONE_Q : '0;
        end else begin
          ov_r[i] <= dsg_r[QB][i] ? -qe[i] : qe[i];
        end
      end
      oid_r <= di_r[QB];
    end
  end

  assign out_tvalid = vld_r[NV-1];
  assign out_tuser  = oid_r;
  assign out_tdata  = OUT_TDW'({ov_r[3], ov_r[2], ov_r[1], ov_r[0]});

endmodule

[hdl/qnlerp_checker.sv]
// Port-level checker for quaternion_nlerp, attached by bind.
// Depends on qnlerp_pkg and quaternion_nlerp_defines.svh.
`include "quaternion_nlerp_defines.svh"

module qnlerp_checker #(
  parameter int COMPONENT_BITS = 16,
  localparam int OUT_TDW = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [OUT_TDW-1:0]               out_tdata,
  input logic                             out_tuser
);
  import qnlerp_pkg::*;

  localparam int W = COMPONENT_BITS;
  localparam logic [W-1:0] ONE_Q = W'(1) << (W - 2);

  logic stalled;
  logic ident_ok;
  assign stalled  = out_tvalid && !out_tready;
  assign ident_ok = (out_tdata[(Q_LANES-1)*W-1:0] == '0) &&
                    (out_tdata[(Q_LANES-1)*W +: W] == ONE_Q);

  // held result stays put until taken
  `QN_ASSERT_NEXT(a_out_hold, stalled, out_tvalid, "result dropped while stalled")
  `QN_ASSERT_NEXT(a_out_stable, stalled, $stable({out_tuser, out_tdata}), "result changed in stall")

  // an empty output never blocks the input
  `QN_ASSERT_NOW(a_in_ready, !out_tvalid, in_tready, "input blocked with empty output")

  // identity flag must come with the identity quaternion
  `QN_ASSERT_NOW(a_ident, out_tvalid && out_tuser, ident_ok, "identity flag without identity value")

  // reset empties the pipeline
  `QN_ASSERT_ALWAYS(a_rst_empty, !rst_n, !out_tvalid, "output valid right after reset")

endmodule

bind quaternion_nlerp qnlerp_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_qnlerp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/quaternion_nlerp_test.sv]
// Self-checking bench for quaternion_nlerp: random and directed quaternion pairs
// with a bit-accurate blend/normalize predictor and an in-order scoreboard.
// Depends on qnlerp_pkg and the quaternion_nlerp RTL.
`timescale 1ns / 100ps

class nlerp_scoreboard;
  typedef struct packed {
    logic [63:0] comps;
    logic        ident;
  } nlerp_result_t;

  nlerp_result_t  pending[$];
  logic [14:0]    min_mag;
  int             mismatches;
  int             checked;
  int             identities;

  function new();
    min_mag    = qnlerp_pkg::MIN_MAG_RESET;
    mismatches = 0;
    checked    = 0;
    identities = 0;
  endfunction

  // floor square root of a 64-bit value, bit by bit
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // compute the expected blend for one accepted input transaction
  function void note_input(logic [151:0] tdata);
    longint        a[4], b[4], r[4];
    longint        dot, full, v;
    longint unsigned t, sum, mag, m, q;
    nlerp_result_t res;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(tdata[16*i +: 16]));
      b[i] = longint'($signed(tdata[64 + 16*i +: 16]));
    end
    t = tdata[128 +: 17];
    if (t > 65536) t = 65536;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += a[i] * b[i];
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      full = a[i] * 65536 + (((dot < 0) ? -b[i] : b[i]) - a[i]) * longint'(t);
      r[i] = (full + 32768) >>> 16;
      m    = (r[i] < 0) ? -r[i] : r[i];
      sum += m * m;
    end
    res.comps = '0;
    if (sum > longint'(min_mag) * longint'(min_mag)) begin
      mag       = root_floor(sum);
      res.ident = 1'b0;
      for (int i = 0; i < 4; i++) begin
        m = (r[i] < 0) ? -r[i] : r[i];
        q = ((m << 14) + (mag >> 1)) / mag;
        if (q > 32768) q = 32768;
        v = (r[i] < 0) ? -longint'(q) : longint'(q);
        if (v > 32767) v = 32767;
        res.comps[16*i +: 16] = v[15:0];
      end
    end else begin
      res.ident             = 1'b1;
      res.comps[48 +: 16]   = 16'h4000;
    end
    pending.push_back(res);
  endfunction

  function void check_result(logic [63:0] tdata, logic tuser);
    nlerp_result_t exp_res;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h ident %b", tdata, tuser);
      return;
    end
    exp_res = pending.pop_front();
    if (exp_res.ident) identities++;
    if (exp_res.comps !== tdata || exp_res.ident !== tuser) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h ident %b, got %h ident %b",
                 exp_res.comps, exp_res.ident, tdata, tuser);
    end
  endfunction
endclass

module quaternion_nlerp_test;
  localparam int LATENCY    = 42;
  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [151:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [14:0]  cfg_data;

  nlerp_scoreboard blend_sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  idle_cycles;
  int  sent;

  quaternion_nlerp uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) blend_sb.note_input(in_tdata);
      if (out_tvalid && out_tready) blend_sb.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("quaternion_nlerp_test: FAIL");
        $finish;
      end
    end
  end

  // receiver readiness, changed at the falling edge
  always @(negedge clk) begin
    if (hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(8)) - 4);
      4, 5:    return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_blend();
    case ($urandom_range(7))
      0:       return 17'd0;
      1:       return 17'h10000;
      2:       return 17'($urandom_range(131071, 65537));
      3:       return 17'h1FFFF;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // valid stays high between back-to-back items; drain() lowers it
  task automatic send_item(logic [151:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [151:0] d;
    d = '0;
    for (int i = 0; i < 8; i++) d[16*i +: 16] = rand_comp();
    // sometimes make b the opposite or equal of a to hit cancellation
    if ($urandom_range(9) == 0)
      for (int i = 0; i < 4; i++) d[64 + 16*i +: 16] = -d[16*i +: 16];
    else if ($urandom_range(9) == 0)
      for (int i = 0; i < 4; i++) d[64 + 16*i +: 16] = d[16*i +: 16];
    d[128 +: 17] = rand_blend();
    send_item(d);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (blend_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_min_mag(logic [14:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    blend_sb.min_mag = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int items, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) send_random();
    drain();
  endtask

  initial begin
    logic [151:0] d;
    blend_sb       = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    out_tready     = 1'b0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_cycles    = 0;
    sent           = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, opposite signs, zero length, blend above one
    for (int k = 0; k < 20; k++) begin
      d = '0;
      case (k)
        0: d[48 +: 16] = 16'h4000;
        1: begin d[48 +: 16] = 16'h4000; d[112 +: 16] = 16'hC000; d[128 +: 17] = 17'h8000; end
        2: d[128 +: 17] = 17'h10000;
        3: begin d[127:0] = {8{16'h8000}}; d[128 +: 17] = 17'h1FFFF; end
        4: begin d[127:0] = {8{16'h7FFF}}; d[128 +: 17] = 17'h10000; end
        5: begin d[63:0] = {4{16'h7FFF}}; d[127:64] = {4{16'h8000}}; d[128 +: 17] = 17'h8000; end
        6: begin d[15:0] = 16'd1; d[128 +: 17] = 17'd0; end
        7: begin d[15:0] = 16'd3; d[128 +: 17] = 17'd0; end
        8: begin d[15:0] = 16'hFFFD; d[79:64] = 16'd3; d[128 +: 17] = 17'h8000; end
        9: begin d[63:0] = {16'h4000, 48'd0}; d[127:64] = {48'd0, 16'h4000}; d[128 +: 17] = 17'h10001; end
        default: for (int i = 0; i < 8; i++) d[16*i +: 16] = rand_comp();
      endcase
      if (k >= 10) d[128 +: 17] = rand_blend();
      send_item(d);
    end
    drain();

    // random phases, each under a different threshold
    write_min_mag(15'd0);
    run_phase(300, 0, 0);
    write_min_mag(15'h7FFF);
    run_phase(200, 75, 0);
    write_min_mag(15'd16384);
    run_phase(300, 0, 75);
    write_min_mag(15'(($urandom_range(200))));
    run_phase(300, 34, 34);
    write_min_mag(15'd2);

    // long receiver hold-off while the sender keeps pushing
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      run_phase(250, 0, 0);
    join
    write_min_mag(15'(($urandom_range(32767))));
    run_phase(480, 20, 20);

    $display("covered %0d inputs, %0d results checked, %0d identity fallbacks",
             sent, blend_sb.checked, blend_sb.identities);
    $display("threshold swept from 0 to 32767 under mixed sender gaps and receiver stalls");
    if (blend_sb.mismatches == 0 && blend_sb.pending.size() == 0)
      $display("quaternion_nlerp_test: PASS");
    else
      $display("quaternion_nlerp_test: FAIL");
    $finish;
  end
endmodule
